// ----- design/hcsf_pkg.sv -----
// Package for the hop-count spoof filter: word types, op codes, table sizing
// and the hop count helper. No dependencies.

package hcsf_pkg;

   localparam int ENTRIES = 1024;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 24;
   localparam int TOL_RESET = 2;

   typedef enum logic [1:0] {
      OP_LOOKUP   = 2'd0,
      OP_REGISTER = 2'd1,
      OP_LOAD     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_UNKNOWN  = 2'd0,
      VERDICT_MISMATCH = 2'd1,
      VERDICT_MATCH    = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] src_addr;
      logic [7:0]  ttl;
      logic [7:0]  hop_count;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       new_entry;
      logic       table_full;
      logic [7:0] hop_count_out;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type          op;
      logic [KEY_W-1:0] key;
      logic [7:0]      hops;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   function automatic logic [7:0] hops_from_ttl(input logic [7:0] t);
      logic [7:0] h;
      if (t <= 8'd64) begin
         h = 8'd64 - t;
      end else if (t <= 8'd128) begin
         h = 8'd128 - t;
      end else begin
         h = 8'd255 - t;
      end
      return h;
   endfunction

endpackage

// ----- design/hcsf_front.sv -----
// Front end: accepts request words, derives the hop count and key, and
// buffers classified items in a two-entry queue. Uses hcsf_pkg.

module hcsf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hcsf_pkg::req_type        req_data,
   output hcsf_pkg::queue_out_type  q_out,
   input  logic                     q_pop
);
   import hcsf_pkg::*;

   item_type   q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   item_type   item_new;
   logic       push, pop;

   always_comb begin
      item_new.op  = op_type'(req_data.op);
      item_new.key = req_data.src_addr[31:8];
      if (req_data.op == OP_LOAD) begin
         item_new.hops = req_data.hop_count;
      end else if (req_data.op == OP_CLEAR) begin
         item_new.hops = 8'd0;
      end else begin
         item_new.hops = hops_from_ttl(req_data.ttl);
      end
   end

   assign req_ready   = (fill_ff != 2'd2);
   assign push        = req_valid && req_ready;
   assign pop         = q_pop && (fill_ff != 2'd0);
   assign q_out.valid = (fill_ff != 2'd0);
   assign q_out.item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ----- design/hcsf_back.sv -----
// Back end: scans the prefix table held in a memory, applies lookups,
// inserts and clears, and holds the response word. Uses hcsf_pkg.

module hcsf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  hcsf_pkg::queue_out_type  q_out,
   output logic                     q_pop,
   input  logic [7:0]               tolerance,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hcsf_pkg::rsp_type        rsp_data
);
   import hcsf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   // word: prefix in upper bits, hop count in lower byte
   logic [KEY_W+7:0] mem [ENTRIES];

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [KEY_W+7:0] rd_data_ff;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [7:0]       hit_hops_ff, hit_hops_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             hit, scan_done, issue_ok, out_free;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       diff;

   assign hit       = rd_vld_ff && (rd_data_ff[KEY_W+7:8] == item_ff.key);
   assign issue_ok  = (issue_ff < count_ff) && !hit;
   assign scan_done = (issue_ff == count_ff) && !rd_vld_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_out.valid;
   assign diff      = (item_ff.hops > hit_hops_ff) ? item_ff.hops - hit_hops_ff
                                                   : hit_hops_ff - item_ff.hops;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      found_in     = found_ff;
      slot_in      = slot_ff;
      hit_hops_in  = hit_hops_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_idx       = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid) begin
               item_in  = q_out.item;
               issue_in = '0;
               found_in = 1'b0;
               state_in = (q_out.item.op == OP_CLEAR) ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_vld_in = issue_ok;
            if (issue_ok) begin
               issue_in = issue_ff + 1'b1;
            end
            if (hit) begin
               found_in    = 1'b1;
               slot_in     = rd_idx_ff;
               hit_hops_in = rd_data_ff[7:0];
               state_in    = ST_RESULT;
            end else if (scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.verdict        = VERDICT_UNKNOWN;
               rsp_in.new_entry      = 1'b0;
               rsp_in.table_full     = 1'b0;
               rsp_in.hop_count_out  = item_ff.hops;
               state_in              = ST_IDLE;
               case (item_ff.op)
                  OP_LOOKUP: begin
                     if (found_ff) begin
                        rsp_in.verdict = (diff <= tolerance) ? VERDICT_MATCH
                                                             : VERDICT_MISMATCH;
                     end
                  end
                  OP_REGISTER, OP_LOAD: begin
                     if (found_ff) begin
                        wr_en = 1'b1;
                     end else if (count_ff < CNT_W'(ENTRIES)) begin
                        wr_en            = 1'b1;
                        wr_idx           = count_ff[IDX_W-1:0];
                        count_in         = count_ff + 1'b1;
                        rsp_in.new_entry = 1'b1;
                     end else begin
                        rsp_in.table_full = 1'b1;
                     end
                  end
                  default: begin
                     count_in             = '0;
                     rsp_in.hop_count_out = 8'd0;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         issue_ff     <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      slot_ff     <= slot_in;
      hit_hops_ff <= hit_hops_in;
      rsp_ff      <= rsp_in;
      rd_idx_ff   <= issue_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
      if (wr_en) begin
         mem[wr_idx] <= {item_ff.key, item_ff.hops};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/hop_count_spoof_filter.sv -----
// Top level of the hop-count spoof filter: tolerance register, front end
// and back end. Uses hcsf_pkg, hcsf_front and hcsf_back.
//
//   port group | direction | handshake           | word
//   req_*      | in        | req_valid/req_ready | hcsf_pkg::req_type
//   rsp_*      | out       | rsp_valid/rsp_ready | hcsf_pkg::rsp_type
//   csr_*      | in/out    | APB, pready high    | hop_tolerance at 0x0
//
// A lookup or insert scans the filled part of the table, one memory read
// per cycle, and stops at the first matching prefix; a clear skips the scan.
// Synchronous reset empties the table at once through its fill count.
// The two-entry queue takes words until it is full while the back end scans
// or the response word waits for rsp_ready.

module hop_count_spoof_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  hcsf_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hcsf_pkg::rsp_type  rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import hcsf_pkg::*;

   logic [7:0]    tol_ff;
   queue_out_type q_out;
   logic          q_pop;

   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, tol_ff};

   // single register: every address decodes to it
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 8'(TOL_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == csr_paddr)) begin
         tol_ff <= csr_pwdata[7:0];
      end
   end

   hcsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   hcsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .tolerance (tol_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
